// ===== rtl/crc32mr_pkg.sv =====
// shared types, constants and the byte-wide crc update for the crc-32 remainder block
`default_nettype none

package crc32mr_pkg;

    localparam int unsigned CrcWidth  = 32;
    localparam int unsigned ByteWidth = 8;

    // generator x^32 + 0x04c11db7, leading term implied
    localparam logic [CrcWidth-1:0] GenPoly = 32'h04C1_1DB7;

    typedef struct packed {
        logic [ByteWidth-1:0] message_byte;
        logic                 has_byte;
        logic                 starts_message;
        logic                 ends_message;
        logic [CrcWidth-1:0]  check_value;
    } item_t;

    // eight msb-first shift/xor steps of the long division
    function automatic logic [CrcWidth-1:0] crc_byte(
        input logic [CrcWidth-1:0]  rem,
        input logic [ByteWidth-1:0] data
    );
        logic [CrcWidth-1:0] r;
        r = rem ^ {data, {(CrcWidth-ByteWidth){1'b0}}};
        for (int n = 0; n < ByteWidth; n++)
        begin
            if (r[CrcWidth-1])
            begin
                r = {r[CrcWidth-2:0], 1'b0} ^ GenPoly;
            end
            else
            begin
                r = {r[CrcWidth-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/crc32mr_update.sv =====
// combinational running-remainder update and result value for one transaction
`default_nettype none

module crc32mr_update
    import crc32mr_pkg::*;
(
    input  wire item_t               item,
    input  wire logic [CrcWidth-1:0] rem_cur,
    output logic      [CrcWidth-1:0] rem_next,
    output logic      [CrcWidth-1:0] result_rem,
    output logic                     result_zero
);

    logic [CrcWidth-1:0] rem_base;
    logic [CrcWidth-1:0] rem_upd;

    always_comb
    begin
        rem_base    = item.starts_message ? '0 : rem_cur;
        rem_upd     = item.has_byte ? crc_byte(rem_base, item.message_byte) : rem_base;
        result_rem  = rem_upd ^ item.check_value;
        result_zero = (result_rem == '0);
        // remainder restarts after every emitted result
        rem_next    = item.ends_message ? '0 : rem_upd;
    end

endmodule

`default_nettype wire

// ===== rtl/crc32_message_remainder_top.sv =====
// top level of the crc-32 message remainder checker
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------------------
//  message  | message_valid / message_stall| message_byte, has_byte, starts_message,
//           |                              | ends_message, check_value
//  result   | result_valid / result_stall  | remainder, remainder_is_zero
//
// one transaction per cycle unless stalled; a result passes the input and result registers
// the pace is set by the single 8-step crc update between the input and result registers
// reset clears the running remainder and both valid flags; no clearing pass is needed
// message_stall rises only while an ending transaction waits behind a stalled result
// transactions that produce no result keep flowing even while the result is stalled
`default_nettype none

module crc32_message_remainder_top
    import crc32mr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 message_valid,
    output logic                      message_stall,
    input  wire logic [ByteWidth-1:0] message_byte,
    input  wire logic                 has_byte,
    input  wire logic                 starts_message,
    input  wire logic                 ends_message,
    input  wire logic [CrcWidth-1:0]  check_value,

    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic      [CrcWidth-1:0]  remainder,
    output logic                      remainder_is_zero
);

    // input register stage
    logic  a_valid_reg;
    logic  a_valid_next;
    item_t a_item_reg;

    // running remainder between messages
    logic [CrcWidth-1:0] run_rem_reg;

    // result register stage
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CrcWidth-1:0] out_rem_reg;
    logic                out_zero_reg;

    logic                msg_accept;
    logic                a_advance;
    logic                out_free;
    logic [CrcWidth-1:0] rem_next;
    logic [CrcWidth-1:0] result_rem;
    logic                result_zero;

    // byte update and result value for the item in the input register
    crc32mr_update u_update (
        .item        (a_item_reg),
        .rem_cur     (run_rem_reg),
        .rem_next    (rem_next),
        .result_rem  (result_rem),
        .result_zero (result_zero)
    );

    always_comb
    begin
        // result slot can take a new value this cycle
        out_free      = !out_valid_reg || !result_stall;
        // items that emit nothing never wait on the result side
        a_advance     = a_valid_reg && (!a_item_reg.ends_message || out_free);
        message_stall = a_valid_reg && !a_advance;
        msg_accept    = message_valid && !message_stall;

        a_valid_next  = msg_accept || (a_valid_reg && !a_advance);

        out_valid_next = out_valid_reg && result_stall;
        if (a_advance && a_item_reg.ends_message)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            run_rem_reg   <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            if (a_advance)
            begin
                run_rem_reg <= rem_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (msg_accept)
        begin
            a_item_reg.message_byte   <= message_byte;
            a_item_reg.has_byte       <= has_byte;
            a_item_reg.starts_message <= starts_message;
            a_item_reg.ends_message   <= ends_message;
            a_item_reg.check_value    <= check_value;
        end
        if (a_advance && a_item_reg.ends_message)
        begin
            out_rem_reg  <= result_rem;
            out_zero_reg <= result_zero;
        end
    end

    assign result_valid      = out_valid_reg;
    assign remainder         = out_rem_reg;
    assign remainder_is_zero = out_zero_reg;

endmodule

`default_nettype wire

// ===== rtl/crc32mr_checker.sv =====
// port-level assertions for the crc-32 remainder checker and their bind
`default_nettype none

module crc32mr_checker
    import crc32mr_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                message_valid,
    input wire logic                message_stall,
    input wire logic                ends_message,
    input wire logic                result_valid,
    input wire logic                result_stall,
    input wire logic [CrcWidth-1:0] remainder,
    input wire logic                remainder_is_zero
);

    // input side only backs up behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        message_stall |-> (result_valid && result_stall))
        else $error("message_stall without a blocked result");

    // a fresh result comes from an accepted ending transaction via the input and result registers
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(message_valid && !message_stall && ends_message, 2))
        else $error("result without an ending transaction");

    // zero flag agrees with the remainder
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (remainder_is_zero == (remainder == '0)))
        else $error("remainder_is_zero disagrees with remainder");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(remainder)))
        else $error("stalled result changed");

endmodule

bind crc32_message_remainder_top crc32mr_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .message_valid     (message_valid),
    .message_stall     (message_stall),
    .ends_message      (ends_message),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .remainder         (remainder),
    .remainder_is_zero (remainder_is_zero)
);

`default_nettype wire
